// File: src/qrm_pkg.sv
// shared types and widths for the quaternion to rotation matrix pipeline
// no dependencies; used by every module of the block
package qrm_pkg;

    localparam int COMP_W  = 16;  // input component and matrix entry width
    localparam int PROD_W  = 32;  // one 16x16 signed product
    localparam int NUMER_W = 34;  // signed numerator, |num| <= norm <= 2^32
    localparam int NORM_W  = 33;  // squared norm, at most 2^32
    localparam int REM_W   = 33;  // divider partial remainder, below den for a nonzero norm
    localparam int DEN_W   = 34;  // divisor, twice the norm
    localparam int QUO_W   = 15;  // quotient bits, result magnitude <= 2^14
    localparam int NUM_ENT = 9;   // entries of the 3x3 rotation part

    localparam logic signed [COMP_W-1:0] ONE_Q14  = 16'sd16384;
    localparam logic [QUO_W-1:0]         QUO_MAX  = 15'd16384;

    // entry indexes, row then column
    localparam int E00 = 0;
    localparam int E01 = 1;
    localparam int E02 = 2;
    localparam int E10 = 3;
    localparam int E11 = 4;
    localparam int E12 = 5;
    localparam int E20 = 6;
    localparam int E21 = 7;
    localparam int E22 = 8;

    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [NUMER_W-1:0] numer_t;

    // pairwise products of one request
    typedef struct packed {
        prod_t xx;
        prod_t yy;
        prod_t zz;
        prod_t ww;
        prod_t xy;
        prod_t xz;
        prod_t yz;
        prod_t wx;
        prod_t wy;
        prod_t wz;
        logic  degen;
    } prod_item_t;

    // squared norm and the nine signed numerators
    typedef struct packed {
        logic [NORM_W-1:0]                 norm;
        logic [NUM_ENT-1:0][NUMER_W-1:0]   numer;
        logic                              degen;
    } sum_item_t;

    // state of the nine restoring dividers sharing one divisor
    typedef struct packed {
        logic [NUM_ENT-1:0]                neg;
        logic [NUM_ENT-1:0][REM_W-1:0]     rem;
        logic [NUM_ENT-1:0][QUO_W-1:0]     quo;
        logic [DEN_W-1:0]                  den;
        logic [QUO_W-1:0]                  low;
        logic                              degen;
    } div_item_t;

endpackage

// File: src/qrm_front.sv
// front end: products, norm and numerators, then divider setup (three stages)
// depends on qrm_pkg
module qrm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qrm_pkg::comp_t      quat_x,
    input  qrm_pkg::comp_t      quat_y,
    input  qrm_pkg::comp_t      quat_z,
    input  qrm_pkg::comp_t      quat_w,
    output logic                out_valid,
    input  logic                out_ready,
    output qrm_pkg::div_item_t  out_item
);

    logic                 prod_valid_reg;
    logic                 sum_valid_reg;
    logic                 prep_valid_reg;
    qrm_pkg::prod_item_t  prod_reg;
    qrm_pkg::prod_item_t  prod_next;
    qrm_pkg::sum_item_t   sum_reg;
    qrm_pkg::sum_item_t   sum_next;
    qrm_pkg::div_item_t   prep_reg;
    qrm_pkg::div_item_t   prep_next;
    logic                 prod_adv;
    logic                 sum_adv;
    logic                 prep_adv;

    // stage advance, bubbles collapse
    assign prep_adv = !prep_valid_reg || out_ready;
    assign sum_adv  = !sum_valid_reg || prep_adv;
    assign prod_adv = !prod_valid_reg || sum_adv;
    assign in_ready = prod_adv;

    // stage 1: pairwise products
    always_comb
    begin
        prod_next.xx    = qrm_pkg::prod_t'(quat_x) * qrm_pkg::prod_t'(quat_x);
        prod_next.yy    = qrm_pkg::prod_t'(quat_y) * qrm_pkg::prod_t'(quat_y);
        prod_next.zz    = qrm_pkg::prod_t'(quat_z) * qrm_pkg::prod_t'(quat_z);
        prod_next.ww    = qrm_pkg::prod_t'(quat_w) * qrm_pkg::prod_t'(quat_w);
        prod_next.xy    = qrm_pkg::prod_t'(quat_x) * qrm_pkg::prod_t'(quat_y);
        prod_next.xz    = qrm_pkg::prod_t'(quat_x) * qrm_pkg::prod_t'(quat_z);
        prod_next.yz    = qrm_pkg::prod_t'(quat_y) * qrm_pkg::prod_t'(quat_z);
        prod_next.wx    = qrm_pkg::prod_t'(quat_w) * qrm_pkg::prod_t'(quat_x);
        prod_next.wy    = qrm_pkg::prod_t'(quat_w) * qrm_pkg::prod_t'(quat_y);
        prod_next.wz    = qrm_pkg::prod_t'(quat_w) * qrm_pkg::prod_t'(quat_z);
        prod_next.degen = (quat_x == '0) && (quat_y == '0) &&
                          (quat_z == '0) && (quat_w == '0);
    end

    // stage 2: squared norm and numerators
    always_comb
    begin
        qrm_pkg::numer_t xx;
        qrm_pkg::numer_t yy;
        qrm_pkg::numer_t zz;
        qrm_pkg::numer_t ww;
        qrm_pkg::numer_t xy;
        qrm_pkg::numer_t xz;
        qrm_pkg::numer_t yz;
        qrm_pkg::numer_t wx;
        qrm_pkg::numer_t wy;
        qrm_pkg::numer_t wz;
        qrm_pkg::numer_t norm_s;
        xx = qrm_pkg::numer_t'(prod_reg.xx);
        yy = qrm_pkg::numer_t'(prod_reg.yy);
        zz = qrm_pkg::numer_t'(prod_reg.zz);
        ww = qrm_pkg::numer_t'(prod_reg.ww);
        xy = qrm_pkg::numer_t'(prod_reg.xy);
        xz = qrm_pkg::numer_t'(prod_reg.xz);
        yz = qrm_pkg::numer_t'(prod_reg.yz);
        wx = qrm_pkg::numer_t'(prod_reg.wx);
        wy = qrm_pkg::numer_t'(prod_reg.wy);
        wz = qrm_pkg::numer_t'(prod_reg.wz);
        norm_s = xx + yy + zz + ww;
        sum_next.norm = norm_s[qrm_pkg::NORM_W-1:0];
        sum_next.numer[qrm_pkg::E00] = xx + ww - yy - zz;
        sum_next.numer[qrm_pkg::E01] = (xy - wz) <<< 1;
        sum_next.numer[qrm_pkg::E02] = (xz + wy) <<< 1;
        sum_next.numer[qrm_pkg::E10] = (xy + wz) <<< 1;
        sum_next.numer[qrm_pkg::E11] = yy + ww - xx - zz;
        sum_next.numer[qrm_pkg::E12] = (yz - wx) <<< 1;
        sum_next.numer[qrm_pkg::E20] = (xz - wy) <<< 1;
        sum_next.numer[qrm_pkg::E21] = (yz + wx) <<< 1;
        sum_next.numer[qrm_pkg::E22] = zz + ww - xx - yy;
        sum_next.degen = prod_reg.degen;
    end

    // stage 3: sign, magnitude and first partial remainder
    // quotient = floor((mag * 2^15 + norm) / (2 * norm)), the upper part
    // of the dividend is mag + norm[32:15], the low 15 bits are norm[14:0]
    always_comb
    begin
        logic [qrm_pkg::NUMER_W-1:0] mag;
        logic [qrm_pkg::REM_W-1:0]   top;
        for (int e = 0; e < qrm_pkg::NUM_ENT; e++)
        begin
            prep_next.neg[e] = sum_reg.numer[e][qrm_pkg::NUMER_W-1];
            mag = prep_next.neg[e] ? (~sum_reg.numer[e] + 1'b1) : sum_reg.numer[e];
            top = qrm_pkg::REM_W'(sum_reg.norm[qrm_pkg::NORM_W-1:qrm_pkg::QUO_W]);
            prep_next.rem[e] = mag[qrm_pkg::REM_W-1:0] + top;
            prep_next.quo[e] = '0;
        end
        prep_next.den   = {sum_reg.norm, 1'b0};
        prep_next.low   = sum_reg.norm[qrm_pkg::QUO_W-1:0];
        prep_next.degen = sum_reg.degen;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod_adv)
                prod_valid_reg <= in_valid;
            if (sum_adv)
                sum_valid_reg <= prod_valid_reg;
            if (prep_adv)
                prep_valid_reg <= sum_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (prod_adv && in_valid)
            prod_reg <= prod_next;
        if (sum_adv && prod_valid_reg)
            sum_reg <= sum_next;
        if (prep_adv && sum_valid_reg)
            prep_reg <= prep_next;
    end

    assign out_valid = prep_valid_reg;
    assign out_item  = prep_reg;

endmodule

// File: src/qrm_divider.sv
// nine restoring dividers in lockstep, one quotient bit per pipeline stage
// depends on qrm_pkg
module qrm_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qrm_pkg::div_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output qrm_pkg::div_item_t  out_item
);

    localparam int STAGES = qrm_pkg::QUO_W;

    qrm_pkg::div_item_t  stage_reg  [STAGES];
    qrm_pkg::div_item_t  stage_next [STAGES];
    logic [STAGES-1:0]   valid_reg;
    wire  [STAGES:0]     adv;
    wire  [STAGES-1:0]   src_valid;

    assign adv[STAGES] = out_ready;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - k;
        qrm_pkg::div_item_t src;

        if (k == 0)
        begin : g_first
            assign src          = in_item;
            assign src_valid[k] = in_valid;
        end
        else
        begin : g_rest
            assign src          = stage_reg[k-1];
            assign src_valid[k] = valid_reg[k-1];
        end

        assign adv[k] = !valid_reg[k] || adv[k+1];

        // shift in the next dividend bit, subtract when it fits
        always_comb
        begin
            logic [qrm_pkg::REM_W:0] shifted;
            logic                    fits;
            stage_next[k] = src;
            for (int e = 0; e < qrm_pkg::NUM_ENT; e++)
            begin
                shifted = {src.rem[e], src.low[BIT]};
                fits    = (qrm_pkg::DEN_W'(shifted) >= src.den);
                if (fits)
                    stage_next[k].rem[e] = qrm_pkg::REM_W'(shifted - src.den);
                else
                    stage_next[k].rem[e] = shifted[qrm_pkg::REM_W-1:0];
                stage_next[k].quo[e] = {src.quo[e][qrm_pkg::QUO_W-2:0], fits};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv[k])
                valid_reg[k] <= src_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_valid[k])
                stage_reg[k] <= stage_next[k];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = stage_reg[STAGES-1];

endmodule

// File: src/quaternion_to_rotation_matrix_top.sv
// an accepted request passes 3 front stages, 15 divider stages and 1 output
// register to reach mat_valid; throughput is one request per cycle while
// mat_stall is low, as every stage can move each cycle, and the 15-stage
// restoring divider (nine lanes, one divisor) sets the depth only
// reset: rst_n clears every valid bit at once; data registers are not reset
// top level: front end, divider pipeline and output register; depends on qrm_pkg
module quaternion_to_rotation_matrix_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quat_valid,
    output logic                quat_stall,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic signed [15:0]  quat_w,
    output logic                mat_valid,
    input  logic                mat_stall,
    output logic signed [15:0]  r00,
    output logic signed [15:0]  r01,
    output logic signed [15:0]  r02,
    output logic signed [15:0]  r10,
    output logic signed [15:0]  r11,
    output logic signed [15:0]  r12,
    output logic signed [15:0]  r20,
    output logic signed [15:0]  r21,
    output logic signed [15:0]  r22,
    output logic                degenerate
);

    logic                front_ready;
    logic                front_valid;
    qrm_pkg::div_item_t  front_item;
    logic                div_ready;
    logic                div_valid;
    qrm_pkg::div_item_t  div_item;
    logic                out_adv;
    logic                out_valid_reg;
    qrm_pkg::comp_t      ent_reg  [qrm_pkg::NUM_ENT];
    qrm_pkg::comp_t      ent_next [qrm_pkg::NUM_ENT];
    logic                degen_reg;

    qrm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quat_valid),
        .in_ready  (front_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .out_valid (front_valid),
        .out_ready (div_ready),
        .out_item  (front_item)
    );

    qrm_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (div_ready),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_ready (out_adv),
        .out_item  (div_item)
    );

    assign quat_stall = !front_ready;
    assign out_adv    = !out_valid_reg || !mat_stall;

    // sign, saturation and the identity for a zero quaternion
    always_comb
    begin
        logic [qrm_pkg::QUO_W-1:0]  q;
        logic [qrm_pkg::COMP_W-1:0] mag;
        for (int e = 0; e < qrm_pkg::NUM_ENT; e++)
        begin
            q   = (div_item.quo[e] > qrm_pkg::QUO_MAX) ? qrm_pkg::QUO_MAX
                                                      : div_item.quo[e];
            mag = {1'b0, q};
            ent_next[e] = div_item.neg[e] ? -$signed(mag) : $signed(mag);
            if (div_item.degen)
                ent_next[e] = '0;
        end
        if (div_item.degen)
        begin
            ent_next[qrm_pkg::E00] = qrm_pkg::ONE_Q14;
            ent_next[qrm_pkg::E11] = qrm_pkg::ONE_Q14;
            ent_next[qrm_pkg::E22] = qrm_pkg::ONE_Q14;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && div_valid)
        begin
            ent_reg   <= ent_next;
            degen_reg <= div_item.degen;
        end
    end

    assign mat_valid  = out_valid_reg;
    assign r00        = ent_reg[qrm_pkg::E00];
    assign r01        = ent_reg[qrm_pkg::E01];
    assign r02        = ent_reg[qrm_pkg::E02];
    assign r10        = ent_reg[qrm_pkg::E10];
    assign r11        = ent_reg[qrm_pkg::E11];
    assign r12        = ent_reg[qrm_pkg::E12];
    assign r20        = ent_reg[qrm_pkg::E20];
    assign r21        = ent_reg[qrm_pkg::E21];
    assign r22        = ent_reg[qrm_pkg::E22];
    assign degenerate = degen_reg;

endmodule

// File: src/qrm_checker.sv
// port-level checks for the quaternion to rotation matrix block, with bind
// depends on qrm_pkg and quaternion_to_rotation_matrix_top
module qrm_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quat_valid,
    input  logic                quat_stall,
    input  logic                mat_valid,
    input  logic                mat_stall,
    input  logic signed [15:0]  r00,
    input  logic signed [15:0]  r01,
    input  logic signed [15:0]  r02,
    input  logic signed [15:0]  r10,
    input  logic signed [15:0]  r11,
    input  logic signed [15:0]  r12,
    input  logic signed [15:0]  r20,
    input  logic signed [15:0]  r21,
    input  logic signed [15:0]  r22,
    input  logic                degenerate
);

    localparam logic signed [15:0] NEG_ONE = -qrm_pkg::ONE_Q14;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_stall |=> mat_valid && $stable(r00) && $stable(r01) &&
        $stable(r02) && $stable(r10) && $stable(r11) && $stable(r12) &&
        $stable(r20) && $stable(r21) && $stable(r22) && $stable(degenerate))
        else $error("stalled result changed");

    // input side only backs up when the whole pipe is full and the output is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        quat_stall |-> mat_valid && mat_stall)
        else $error("input stalled while the pipeline has room");

    // zero quaternion gives the identity
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && degenerate |->
        r00 == qrm_pkg::ONE_Q14 && r11 == qrm_pkg::ONE_Q14 && r22 == qrm_pkg::ONE_Q14 &&
        r01 == 16'sd0 && r02 == 16'sd0 && r10 == 16'sd0 &&
        r12 == 16'sd0 && r20 == 16'sd0 && r21 == 16'sd0)
        else $error("degenerate result is not the identity");

    // entries of a rotation stay within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid |->
        r00 >= NEG_ONE && r00 <= qrm_pkg::ONE_Q14 && r01 >= NEG_ONE && r01 <= qrm_pkg::ONE_Q14 &&
        r02 >= NEG_ONE && r02 <= qrm_pkg::ONE_Q14 && r10 >= NEG_ONE && r10 <= qrm_pkg::ONE_Q14 &&
        r11 >= NEG_ONE && r11 <= qrm_pkg::ONE_Q14 && r12 >= NEG_ONE && r12 <= qrm_pkg::ONE_Q14 &&
        r20 >= NEG_ONE && r20 <= qrm_pkg::ONE_Q14 && r21 >= NEG_ONE && r21 <= qrm_pkg::ONE_Q14 &&
        r22 >= NEG_ONE && r22 <= qrm_pkg::ONE_Q14)
        else $error("matrix entry out of range");

endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (.*);
